// ===== src/des_round_key_schedule_macros.svh =====
// Assertion helpers shared by the key schedule RTL.
`ifndef DES_ROUND_KEY_SCHEDULE_MACROS_SVH
`define DES_ROUND_KEY_SCHEDULE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DRKS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DRKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/drks_pkg.sv =====
`timescale 1ns / 1ps

package drks_pkg;

    localparam int KEY_BITS   = 64;
    localparam int HALF_BITS  = 28;
    localparam int KEY56_BITS = 56;
    localparam int SUB_BITS   = 48;
    localparam int ROUND_BITS = 4;

    localparam logic [ROUND_BITS-1:0] FIRST_ROUND = 4'd0;
    localparam logic [ROUND_BITS-1:0] LAST_ROUND  = 4'd15;

    localparam int PC1 [KEY56_BITS] = '{
        57, 49, 41, 33, 25, 17, 9, 1, 58, 50, 42, 34, 26, 18,
        10, 2, 59, 51, 43, 35, 27, 19, 11, 3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15, 7, 62, 54, 46, 38, 30, 22,
        14, 6, 61, 53, 45, 37, 29, 21, 13, 5, 28, 20, 12, 4
    };

    localparam int PC2 [SUB_BITS] = '{
        14, 17, 11, 24, 1, 5, 3, 28, 15, 6, 21, 10,
        23, 19, 12, 4, 26, 8, 16, 7, 27, 20, 13, 2,
        41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
    };

    // Control shared by every bit cell of both rings.
    typedef struct packed {
        logic load;
        logic advance;
        logic shift2;
    } t_ring_ctrl;

    // Table positions count from 1 at the MSB.
    function automatic logic [KEY56_BITS-1:0] perm_choice1(input logic [KEY_BITS-1:0] key);
        logic [KEY56_BITS-1:0] acc;
        acc = '0;
        for (int k = 0; k < KEY56_BITS; k++) begin
            acc[KEY56_BITS-1-k] = key[KEY_BITS-PC1[k]];
        end
        return acc;
    endfunction

    function automatic logic [SUB_BITS-1:0] perm_choice2(input logic [KEY56_BITS-1:0] cd);
        logic [SUB_BITS-1:0] acc;
        acc = '0;
        for (int k = 0; k < SUB_BITS; k++) begin
            acc[SUB_BITS-1-k] = cd[KEY56_BITS-PC2[k]];
        end
        return acc;
    endfunction

    // Rounds 1, 2, 9 and 16 rotate by one, all others by two.
    function automatic logic round_shift2(input logic [ROUND_BITS-1:0] rnd);
        logic s2;
        case (rnd) inside
            4'd0, 4'd1, 4'd8, 4'd15: s2 = 1'b0;
            default:                 s2 = 1'b1;
        endcase
        return s2;
    endfunction

endpackage

// ===== src/drks_bit_cell.sv =====
`timescale 1ns / 1ps

module drks_bit_cell
    import drks_pkg::*;
(
    input  logic       i_clk,
    input  t_ring_ctrl i_ctrl,
    input  logic       i_load_bit,
    input  logic       i_near,
    input  logic       i_far,
    output logic       o_bit,
    output logic       o_rot
);

    logic r_bit;
    logic n_bit;

    assign o_rot = i_ctrl.shift2 ? i_far : i_near;

    // Load wins over rotation: the last rotation of a key is not needed.
    always_comb begin
        n_bit = r_bit;
        if (i_ctrl.load) begin
            n_bit = i_load_bit;
        end else if (i_ctrl.advance) begin
            n_bit = o_rot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

// ===== src/drks_half_ring.sv =====
`timescale 1ns / 1ps

module drks_half_ring
    import drks_pkg::*;
(
    input  logic                 i_clk,
    input  t_ring_ctrl           i_ctrl,
    input  logic [HALF_BITS-1:0] i_load,
    output logic [HALF_BITS-1:0] o_rot
);

    logic [HALF_BITS-1:0] w_bit;

    // Left rotation: each cell takes the bit one or two places below it.
    for (genvar i = 0; i < HALF_BITS; i++) begin : g_cell
        localparam int NEAR = (i + HALF_BITS - 1) % HALF_BITS;
        localparam int FAR  = (i + HALF_BITS - 2) % HALF_BITS;

        drks_bit_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (i_ctrl),
            .i_load_bit (i_load[i]),
            .i_near     (w_bit[NEAR]),
            .i_far      (w_bit[FAR]),
            .o_bit      (w_bit[i]),
            .o_rot      (o_rot[i])
        );
    end

endmodule

// ===== src/des_round_key_schedule.sv =====
`timescale 1ns / 1ps
// DES key schedule.
// Input channel (i_in_valid / o_in_ready) transfers one 64-bit key. The key
// is reduced by PC1 into two 28-bit rings of bit cells; each round rotates
// both rings by one or two places and PC2 of the rotated value is registered.
// Output channel (o_out_valid / i_out_ready) transfers sixteen subkeys per
// key in generation order, with the storage slot and a last-subkey flag.
// The transferred key is loaded into the rings before the first subkey is
// registered. Throughput: one subkey per cycle while the receiver does not
// stall, set by the one rotation step of the rings per cycle. The next key is
// taken in the cycle its predecessor's last subkey is produced, so keys run
// back to back. A stalled receiver freezes the rings and round counter; the
// pending subkey holds in the output register.
// Configuration (i_cfg_valid / o_cfg_ready) writes decrypt mode, always
// ready; write it only between keys.
// Reset (i_rst_n, synchronous, active low) empties the pipeline and clears
// decrypt mode.

module des_round_key_schedule
    import drks_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [KEY_BITS-1:0]   i_cipher_key,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SUB_BITS-1:0]   o_round_key,
    output logic [ROUND_BITS-1:0] o_key_slot,
    output logic                  o_final_round
);

`include "des_round_key_schedule_macros.svh"

    logic                  r_busy;
    logic                  n_busy;
    logic [ROUND_BITS-1:0] r_round;
    logic [ROUND_BITS-1:0] n_round;
    logic                  r_decrypt;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [SUB_BITS-1:0]   r_round_key;
    logic [ROUND_BITS-1:0] r_key_slot;
    logic                  r_final;

    logic                  advance;
    logic                  last;
    logic                  accept;
    t_ring_ctrl            ctrl;
    logic [KEY56_BITS-1:0] pc1_val;
    logic [HALF_BITS-1:0]  c_rot;
    logic [HALF_BITS-1:0]  d_rot;

    assign advance    = r_busy && (!r_out_valid || i_out_ready);
    assign last       = (r_round == LAST_ROUND);
    assign o_in_ready = !r_busy || (advance && last);
    assign accept     = i_in_valid && o_in_ready;

    assign pc1_val      = perm_choice1(i_cipher_key);
    assign ctrl.load    = accept;
    assign ctrl.advance = advance;
    assign ctrl.shift2  = round_shift2(r_round);

    drks_half_ring u_ring_c (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_load (pc1_val[KEY56_BITS-1:HALF_BITS]),
        .o_rot  (c_rot)
    );

    drks_half_ring u_ring_d (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_load (pc1_val[HALF_BITS-1:0]),
        .o_rot  (d_rot)
    );

    always_comb begin
        n_busy  = r_busy;
        n_round = r_round;
        if (accept) begin
            n_busy  = 1'b1;
            n_round = FIRST_ROUND;
        end else if (advance) begin
            n_busy  = !last;
            n_round = r_round + 4'd1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_round     <= FIRST_ROUND;
            r_decrypt   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_decrypt <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_round_key <= perm_choice2({c_rot, d_rot});
            r_key_slot  <= r_decrypt ? (LAST_ROUND - r_round) : r_round;
            r_final     <= last;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_round_key   = r_round_key;
    assign o_key_slot    = r_key_slot;
    assign o_final_round = r_final;

    `DRKS_ASSERT_NEXT(a_accept_starts, accept, r_busy && (r_round == FIRST_ROUND),
        "key transfer did not start round 0")
    `DRKS_ASSERT_NOW(a_idle_round_zero, !r_busy, r_round == FIRST_ROUND,
        "round counter not at 0 while idle")
    `DRKS_ASSERT_NEXT(a_advance_emits, advance, r_out_valid,
        "round advanced without a subkey in the output register")
    `DRKS_ASSERT_NEXT(a_round_steps, advance && !last,
        r_busy && (r_round == 4'($past(r_round) + 4'd1)),
        "round counter did not step")

endmodule
